// ----- rtl/window_data_quality_score_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the window data quality score unit
// Each macro checks a property on the rising edge of aclk outside reset.
// ----------------------------------------------------------------------------
`ifndef WINDOW_DATA_QUALITY_SCORE_UNIT_DEFINES_SVH
`define WINDOW_DATA_QUALITY_SCORE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define WDQS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WDQS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wdqs_pkg.sv -----
// ----------------------------------------------------------------------------
// wdqs_pkg
// Types and constants shared by the window data quality score unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wdqs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_WGT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTL_WGT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_WGT    = 3'd4;

    localparam logic [9:0] GAP_LIMIT_RST = 10'd5;
    localparam logic [3:0] Z_LIMIT_RST   = 4'd5;
    localparam logic [7:0] MISS_WGT_RST  = 8'd100;
    localparam logic [7:0] OUTL_WGT_RST  = 8'd50;
    localparam logic [7:0] GAP_WGT_RST   = 8'd20;

    localparam logic [14:0] SCORE_FULL = 15'd25600;
    localparam logic [5:0]  COUNT_MAX  = 6'd63;

    localparam int ENTRY_W = 34;

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_SUM_RD  = 18'h00002,
        ST_SUM_ACC = 18'h00004,
        ST_DEV_RD  = 18'h00008,
        ST_DEV_NP  = 18'h00010,
        ST_DEV_D   = 18'h00020,
        ST_DEV_SQ0 = 18'h00040,
        ST_DEV_SQ1 = 18'h00080,
        ST_DEV_SQ2 = 18'h00100,
        ST_DEV_USE = 18'h00200,
        ST_DEV_CMP = 18'h00400,
        ST_ZV      = 18'h00800,
        ST_WSUM    = 18'h01000,
        ST_DIVI    = 18'h02000,
        ST_DIV     = 18'h04000,
        ST_SCORE   = 18'h08000,
        ST_STORE   = 18'h10000,
        ST_OUT     = 18'h20000
    } state_t;

endpackage

// ----- rtl/wdqs_ram.sv -----
// ----------------------------------------------------------------------------
// wdqs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/window_data_quality_score_unit.sv -----
// ----------------------------------------------------------------------------
// window_data_quality_score_unit
// Rolling data quality score over the last WINDOW bars of a price stream.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word
//  s_       in         tdata: close_price, stamp_minutes; tuser: close_missing
//  m_       out        tdata: score and counts;           tuser: valid_res
//  cfg_     in         register index and write data, no read-back
//
//  With a full window a bar goes, between acceptance and the next ready cycle, through
//  a sum over every entry, a variance pass and an outlier pass over the present prices
//  on the shared squaring multiplier (missing ones skip it), then weighting, reciprocal
//  division, store and output. While the window fills a bar only stores and outputs.
//  A result waits in the output register and the next bar may be taken meanwhile;
//  a new result stalls until that register is free. Reset is synchronous.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "window_data_quality_score_unit_defines.svh"

module window_data_quality_score_unit #(
    parameter int WINDOW = 60
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [71:0]                     s_tdata,  // close_price, stamp_minutes
    input  logic                            s_tuser,  // close_missing
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // score, missing_count, outlier_hits, gap_count
    output logic [39:0]                     m_tdata,
    output logic                            m_tuser,  // valid_res
    input  logic                            cfg_wr_en,
    input  logic [wdqs_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wdqs_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int D_W   = 32 + CNT_W;
    localparam int HALF  = (D_W + 1) / 2;
    localparam int SQ_W  = 2 * D_W;
    localparam int V_W   = SQ_W + CNT_W;
    localparam int ZV_W  = V_W + 8;
    localparam int WS_W  = CNT_W + 10;
    localparam int NUM_W = WS_W + 8;
    localparam int CX_W  = (CNT_W > 6) ? CNT_W : 6;
    localparam int DIV_L = $clog2(WINDOW);
    localparam int DIV_K = NUM_W + DIV_L;
    localparam int RCP_W = NUM_W + 1;
    localparam logic [RCP_W-1:0] DIV_RCP =
        RCP_W'(((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    wdqs_pkg::state_t state_reg, state_next;

    logic [9:0]       gap_limit_reg;
    logic [3:0]       z_limit_reg;
    logic [7:0]       miss_wgt_reg, outl_wgt_reg, gap_wgt_reg;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pass_reg, pass_next;
    logic [1:0]       wk_reg, wk_next;
    logic [31:0]      price_in_reg, price_in_next;
    logic             miss_in_reg, miss_in_next;
    logic             gap_in_reg, gap_in_next;
    logic [39:0]      last_stamp_reg, last_stamp_next;
    logic             seen_first_reg, seen_first_next;
    logic [CNT_W-1:0] nans_reg, nans_next;
    logic [CNT_W-1:0] gaps_reg, gaps_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] outl_reg, outl_next;
    logic [D_W-1:0]   s_reg, s_next;
    logic [D_W-1:0]   np_reg, np_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [V_W-1:0]   v_reg, v_next;
    logic [V_W-1:0]   nsq_reg, nsq_next;
    logic [ZV_W-1:0]  zv_reg, zv_next;
    logic [WS_W-1:0]  w_reg, w_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             res_valid_reg, res_valid_next;
    logic [14:0]      res_score_reg, res_score_next;
    logic [5:0]       res_miss_reg, res_miss_next;
    logic [5:0]       res_outl_reg, res_outl_next;
    logic [5:0]       res_gap_reg, res_gap_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_user_reg, m_user_next;
    logic [39:0]      m_data_reg, m_data_next;

    logic                         ram_we;
    logic [wdqs_pkg::ENTRY_W-1:0] ram_rdata;
    logic [31:0]                  rd_price;
    logic                         rd_miss, rd_gap;

    logic [39:0]       in_stamp, stamp_diff;
    logic              gap_now;
    logic [HALF-1:0]   dl, dh, mul_a, mul_b;
    logic [2*HALF-1:0] mul_p;
    logic [D_W-1:0]    np_full;
    logic [V_W-1:0]    nsq_full;
    logic [7:0]        z_sq;
    logic [ZV_W-1:0]   zv_full;
    logic [CNT_W-1:0]  w_cnt;
    logic [7:0]        w_wgt;
    logic [WS_W-1:0]   w_prod;
    logic              entry_last;
    logic [CNT_W-1:0]  n_acc;
    logic [NUM_W+RCP_W-1:0] div_prod;
    logic [NUM_W-1:0]  num_init;

    wdqs_ram #(
        .WIDTH (wdqs_pkg::ENTRY_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_reg),
        .wr_data ({gap_in_reg, miss_in_reg, price_in_reg}),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    assign rd_price = ram_rdata[31:0];
    assign rd_miss  = ram_rdata[32];
    assign rd_gap   = ram_rdata[33];

    assign in_stamp   = s_tdata[71:32];
    assign stamp_diff = in_stamp - last_stamp_reg;
    assign gap_now    = seen_first_reg && (in_stamp > last_stamp_reg) &&
                        (stamp_diff > 40'(gap_limit_reg));

    assign dl    = d_reg[HALF-1:0];
    assign dh    = HALF'(d_reg[D_W-1:HALF]);
    assign mul_a = (state_reg == wdqs_pkg::ST_DEV_SQ2) ? dh : dl;
    assign mul_b = (state_reg == wdqs_pkg::ST_DEV_SQ0) ? dl : dh;
    assign mul_p = mul_a * mul_b;

    assign np_full  = n_reg * rd_price;
    assign nsq_full = n_reg * sq_reg;
    assign z_sq     = z_limit_reg * z_limit_reg;
    assign zv_full  = z_sq * v_reg;
    assign w_prod   = w_cnt * w_wgt;
    assign num_init = {w_reg, 8'd0} + NUM_W'(WINDOW / 2);
    assign div_prod = num_reg * DIV_RCP;

    assign entry_last = (idx_reg == IDX_W'(WINDOW - 1));

    always_comb begin
        case (wk_reg)
            2'd0: begin
                w_cnt = nans_reg;
                w_wgt = miss_wgt_reg;
            end
            2'd1: begin
                w_cnt = outl_reg;
                w_wgt = outl_wgt_reg;
            end
            default: begin
                w_cnt = gaps_reg;
                w_wgt = gap_wgt_reg;
            end
        endcase
    end

    function automatic logic [5:0] sat_count(input logic [CNT_W-1:0] cnt);
        logic [CX_W-1:0] ext;
        ext = CX_W'(cnt);
        return (ext > CX_W'(wdqs_pkg::COUNT_MAX)) ? wdqs_pkg::COUNT_MAX : ext[5:0];
    endfunction

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        pass_next       = pass_reg;
        wk_next         = wk_reg;
        price_in_next   = price_in_reg;
        miss_in_next    = miss_in_reg;
        gap_in_next     = gap_in_reg;
        last_stamp_next = last_stamp_reg;
        seen_first_next = seen_first_reg;
        nans_next       = nans_reg;
        gaps_next       = gaps_reg;
        n_next          = n_reg;
        outl_next       = outl_reg;
        s_next          = s_reg;
        np_next         = np_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        v_next          = v_reg;
        nsq_next        = nsq_reg;
        zv_next         = zv_reg;
        w_next          = w_reg;
        num_next        = num_reg;
        res_valid_next  = res_valid_reg;
        res_score_next  = res_score_reg;
        res_miss_next   = res_miss_reg;
        res_outl_next   = res_outl_reg;
        res_gap_next    = res_gap_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_user_next     = m_user_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        n_acc           = n_reg;

        case (state_reg)
            wdqs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    price_in_next   = s_tdata[31:0];
                    miss_in_next    = s_tuser;
                    gap_in_next     = gap_now;
                    last_stamp_next = in_stamp;
                    seen_first_next = 1'b1;
                    nans_next       = '0;
                    gaps_next       = '0;
                    n_next          = '0;
                    outl_next       = '0;
                    s_next          = '0;
                    v_next          = '0;
                    w_next          = '0;
                    wk_next         = '0;
                    idx_next        = '0;
                    pass_next       = 1'b0;
                    res_valid_next  = 1'b0;
                    res_score_next  = '0;
                    res_miss_next   = '0;
                    res_outl_next   = '0;
                    res_gap_next    = '0;
                    state_next      = (fill_reg == CNT_W'(WINDOW)) ?
                                      wdqs_pkg::ST_SUM_RD : wdqs_pkg::ST_STORE;
                end
            end
            wdqs_pkg::ST_SUM_RD: begin
                state_next = wdqs_pkg::ST_SUM_ACC;
            end
            wdqs_pkg::ST_SUM_ACC: begin
                if (rd_miss) begin
                    nans_next = nans_reg + CNT_W'(1);
                end else begin
                    n_acc  = n_reg + CNT_W'(1);
                    s_next = s_reg + D_W'(rd_price);
                end
                n_next = n_acc;
                if (rd_gap) begin
                    gaps_next = gaps_reg + CNT_W'(1);
                end
                if (entry_last) begin
                    idx_next   = '0;
                    state_next = (n_acc == '0) ? wdqs_pkg::ST_WSUM : wdqs_pkg::ST_DEV_RD;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = wdqs_pkg::ST_SUM_RD;
                end
            end
            wdqs_pkg::ST_DEV_RD: begin
                state_next = wdqs_pkg::ST_DEV_NP;
            end
            wdqs_pkg::ST_DEV_NP: begin
                if (rd_miss) begin
                    if (entry_last) begin
                        idx_next   = '0;
                        state_next = pass_reg ? wdqs_pkg::ST_WSUM : wdqs_pkg::ST_ZV;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = wdqs_pkg::ST_DEV_RD;
                    end
                end else begin
                    np_next    = np_full;
                    state_next = wdqs_pkg::ST_DEV_D;
                end
            end
            wdqs_pkg::ST_DEV_D: begin
                d_next     = (np_reg >= s_reg) ? (np_reg - s_reg) : (s_reg - np_reg);
                state_next = wdqs_pkg::ST_DEV_SQ0;
            end
            wdqs_pkg::ST_DEV_SQ0: begin
                sq_next    = SQ_W'(mul_p);
                state_next = wdqs_pkg::ST_DEV_SQ1;
            end
            wdqs_pkg::ST_DEV_SQ1: begin
                sq_next    = sq_reg + (SQ_W'(mul_p) << (HALF + 1));
                state_next = wdqs_pkg::ST_DEV_SQ2;
            end
            wdqs_pkg::ST_DEV_SQ2: begin
                sq_next    = sq_reg + (SQ_W'(mul_p) << (2 * HALF));
                state_next = wdqs_pkg::ST_DEV_USE;
            end
            wdqs_pkg::ST_DEV_USE: begin
                if (pass_reg) begin
                    nsq_next   = nsq_full;
                    state_next = wdqs_pkg::ST_DEV_CMP;
                end else begin
                    v_next = v_reg + V_W'(sq_reg);
                    if (entry_last) begin
                        idx_next   = '0;
                        state_next = wdqs_pkg::ST_ZV;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = wdqs_pkg::ST_DEV_RD;
                    end
                end
            end
            wdqs_pkg::ST_DEV_CMP: begin
                if (ZV_W'(nsq_reg) > zv_reg) begin
                    outl_next = outl_reg + CNT_W'(1);
                end
                if (entry_last) begin
                    idx_next   = '0;
                    state_next = wdqs_pkg::ST_WSUM;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = wdqs_pkg::ST_DEV_RD;
                end
            end
            wdqs_pkg::ST_ZV: begin
                zv_next    = zv_full;
                pass_next  = 1'b1;
                idx_next   = '0;
                state_next = wdqs_pkg::ST_DEV_RD;
            end
            wdqs_pkg::ST_WSUM: begin
                w_next = w_reg + w_prod;
                if (wk_reg == 2'd2) begin
                    wk_next    = '0;
                    state_next = wdqs_pkg::ST_DIVI;
                end else begin
                    wk_next = wk_reg + 2'd1;
                end
            end
            wdqs_pkg::ST_DIVI: begin
                num_next   = num_init;
                state_next = wdqs_pkg::ST_DIV;
            end
            wdqs_pkg::ST_DIV: begin
                num_next   = NUM_W'(div_prod >> DIV_K);
                state_next = wdqs_pkg::ST_SCORE;
            end
            wdqs_pkg::ST_SCORE: begin
                res_valid_next = 1'b1;
                res_score_next = (num_reg >= NUM_W'(wdqs_pkg::SCORE_FULL)) ? 15'd0 :
                                 (wdqs_pkg::SCORE_FULL - num_reg[14:0]);
                res_miss_next  = sat_count(nans_reg);
                res_outl_next  = sat_count(outl_reg);
                res_gap_next   = sat_count(gaps_reg);
                state_next     = wdqs_pkg::ST_STORE;
            end
            wdqs_pkg::ST_STORE: begin
                ram_we     = 1'b1;
                slot_next  = (slot_reg == IDX_W'(WINDOW - 1)) ? '0 : slot_reg + IDX_W'(1);
                fill_next  = (fill_reg == CNT_W'(WINDOW)) ? fill_reg : fill_reg + CNT_W'(1);
                state_next = wdqs_pkg::ST_OUT;
            end
            wdqs_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_valid_reg;
                    m_data_next  = {7'd0, res_gap_reg, res_outl_reg, res_miss_reg,
                                    res_score_reg};
                    state_next   = wdqs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wdqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wdqs_pkg::ST_IDLE;
            slot_reg       <= '0;
            fill_reg       <= '0;
            last_stamp_reg <= '0;
            seen_first_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
            pass_reg       <= 1'b0;
            wk_reg         <= '0;
            gap_limit_reg  <= wdqs_pkg::GAP_LIMIT_RST;
            z_limit_reg    <= wdqs_pkg::Z_LIMIT_RST;
            miss_wgt_reg   <= wdqs_pkg::MISS_WGT_RST;
            outl_wgt_reg   <= wdqs_pkg::OUTL_WGT_RST;
            gap_wgt_reg    <= wdqs_pkg::GAP_WGT_RST;
        end else begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            last_stamp_reg <= last_stamp_next;
            seen_first_reg <= seen_first_next;
            m_valid_reg    <= m_valid_next;
            idx_reg        <= idx_next;
            pass_reg       <= pass_next;
            wk_reg         <= wk_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    wdqs_pkg::CFG_GAP_LIMIT: gap_limit_reg <= cfg_wr_data;
                    wdqs_pkg::CFG_Z_LIMIT:   z_limit_reg   <= cfg_wr_data[3:0];
                    wdqs_pkg::CFG_MISS_WGT:  miss_wgt_reg  <= cfg_wr_data[7:0];
                    wdqs_pkg::CFG_OUTL_WGT:  outl_wgt_reg  <= cfg_wr_data[7:0];
                    wdqs_pkg::CFG_GAP_WGT:   gap_wgt_reg   <= cfg_wr_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        price_in_reg  <= price_in_next;
        miss_in_reg   <= miss_in_next;
        gap_in_reg    <= gap_in_next;
        nans_reg      <= nans_next;
        gaps_reg      <= gaps_next;
        n_reg         <= n_next;
        outl_reg      <= outl_next;
        s_reg         <= s_next;
        np_reg        <= np_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        v_reg         <= v_next;
        nsq_reg       <= nsq_next;
        zv_reg        <= zv_next;
        w_reg         <= w_next;
        num_reg       <= num_next;
        res_valid_reg <= res_valid_next;
        res_score_reg <= res_score_next;
        res_miss_reg  <= res_miss_next;
        res_outl_reg  <= res_outl_next;
        res_gap_reg   <= res_gap_next;
        m_user_reg    <= m_user_next;
        m_data_reg    <= m_data_next;
    end

    assign s_tready = (state_reg == wdqs_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    `WDQS_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "Input accepted twice in a row.")
    `WDQS_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CNT_W'(WINDOW),
        "Fill count ran past the window length.")
    `WDQS_ASSERT_IMP(a_fill_zero, m_tvalid && !m_tuser, m_tdata == '0,
        "Result before a full window carries nonzero fields.")

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for window_data_quality_score_unit
// Drives bars into the unit with random idle cycles on both stream sides and
// compares every output word with a bit-accurate score predictor kept here.
// It runs through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int WIN = 60;

    typedef struct packed {
        logic        valid_res;
        logic [14:0] score_q8;
        logic [5:0]  missing_count;
        logic [5:0]  outl_hits;
        logic [5:0]  gap_count;
    } score_word_t;

    typedef struct {
        logic [31:0] price;
        logic        missing;
        logic [39:0] stamp;
    } bar_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [wdqs_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [wdqs_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    always #1 aclk = ~aclk;

    window_data_quality_score_unit #(.WINDOW(WIN)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    // Predictor state and register copies.
    logic [31:0] price_hist [WIN];
    logic        miss_hist [WIN];
    logic        gap_hist [WIN];
    logic [39:0] prev_stamp = '0;
    logic        have_prev = 1'b0;
    int          bars_seen = 0;
    int          next_slot = 0;
    logic [9:0]  gap_limit = wdqs_pkg::GAP_LIMIT_RST;
    logic [3:0]  z_limit = wdqs_pkg::Z_LIMIT_RST;
    logic [7:0]  miss_wgt = wdqs_pkg::MISS_WGT_RST;
    logic [7:0]  outl_wgt = wdqs_pkg::OUTL_WGT_RST;
    logic [7:0]  gap_wgt = wdqs_pkg::GAP_WGT_RST;

    score_word_t pending_scores [$];
    int          mismatches = 0;
    int          send_gap = 0;

    function automatic logic [5:0] sat63(int c);
        return (c > 63) ? 6'd63 : c[5:0];
    endfunction

    function automatic logic [63:0] dev_of(logic [63:0] n, logic [31:0] p, logic [63:0] s);
        logic [63:0] np;
        np = n * p;
        return (np >= s) ? np - s : s - np;
    endfunction

    function automatic score_word_t score_bar(logic [31:0] price, logic missing,
                                              logic [39:0] stamp);
        score_word_t r;
        logic gap_now;
        int nans, gaps, outl;
        logic [63:0] n, s, w, pen, d;
        logic [127:0] var_sum, zv, lhs, dd;
        r = '0;
        gap_now = have_prev && stamp > prev_stamp && (stamp - prev_stamp) > gap_limit;
        if (bars_seen >= WIN) begin
            nans = 0; gaps = 0; outl = 0; n = 0; s = 0; var_sum = 0;
            for (int k = 0; k < WIN; k++) begin
                if (miss_hist[k]) nans++;
                else begin
                    n++;
                    s += price_hist[k];
                end
                if (gap_hist[k]) gaps++;
            end
            if (n > 0) begin
                for (int k = 0; k < WIN; k++) begin
                    if (!miss_hist[k]) begin
                        dd = dev_of(n, price_hist[k], s);
                        var_sum += dd * dd;
                    end
                end
                zv = var_sum * (z_limit * z_limit);
                for (int k = 0; k < WIN; k++) begin
                    if (!miss_hist[k]) begin
                        dd = dev_of(n, price_hist[k], s);
                        lhs = dd * dd * n;
                        if (lhs > zv) outl++;
                    end
                end
            end
            w = nans * miss_wgt + outl * outl_wgt + gaps * gap_wgt;
            pen = (w * 256 + WIN / 2) / WIN;
            r.valid_res = 1'b1;
            r.score_q8 = (pen >= 25600) ? 15'd0 : 15'(25600 - pen);
            r.missing_count = sat63(nans);
            r.outl_hits = sat63(outl);
            r.gap_count = sat63(gaps);
        end
        price_hist[next_slot] = price;
        miss_hist[next_slot] = missing;
        gap_hist[next_slot] = gap_now;
        next_slot = (next_slot + 1) % WIN;
        if (bars_seen < WIN) bars_seen++;
        prev_stamp = stamp;
        have_prev = 1'b1;
        return r;
    endfunction

    task automatic write_reg(logic [wdqs_pkg::CFG_IDX_W-1:0] idx, logic [9:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            wdqs_pkg::CFG_GAP_LIMIT: gap_limit = val;
            wdqs_pkg::CFG_Z_LIMIT:   z_limit = val[3:0];
            wdqs_pkg::CFG_MISS_WGT:  miss_wgt = val[7:0];
            wdqs_pkg::CFG_OUTL_WGT:  outl_wgt = val[7:0];
            wdqs_pkg::CFG_GAP_WGT:   gap_wgt = val[7:0];
            default: ;
        endcase
    endtask

    task automatic send_bar(logic [31:0] price, logic missing, logic [39:0] stamp,
                            logic use_typed, score_word_t typed);
        score_word_t predicted;
        if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (send_gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, price};
        s_tuser <= missing;
        do @(posedge aclk); while (!s_tready);
        predicted = score_bar(price, missing, stamp);
        pending_scores = {pending_scores, (use_typed ? typed : predicted)};
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        send_gap = 0;
        while (pending_scores.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Output side: random stalls, every word checked against the oldest prediction.
    initial begin
        score_word_t got, want;
        int stall;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = {m_tuser, m_tdata[14:0], m_tdata[20:15], m_tdata[26:21], m_tdata[32:27]};
            if (pending_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = pending_scores.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected v=%0d s=%0d m=%0d o=%0d g=%0d",
                                 want.valid_res, want.score_q8, want.missing_count,
                                 want.outl_hits, want.gap_count);
                        $display("          actual   v=%0d s=%0d m=%0d o=%0d g=%0d",
                                 got.valid_res, got.score_q8, got.missing_count,
                                 got.outl_hits, got.gap_count);
                    end
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("window_data_quality_score_unit regression: fail");
        $finish;
    end

    initial begin
        bar_row_t dir_rows [20];
        logic [39:0] stamp;
        logic [31:0] base, price;
        logic missing;
        int style, span, r;
        dir_rows = '{
            '{32'h0000_0000, 1'b0, 40'd0},
            '{32'hFFFF_FFFF, 1'b0, 40'd0},
            '{32'h0000_0100, 1'b1, 40'd5},
            '{32'h0000_0100, 1'b0, 40'd11},
            '{32'h0000_0100, 1'b0, 40'd10},
            '{32'h0000_0100, 1'b0, 40'd10},
            '{32'hFFFF_FFFF, 1'b1, 40'hFF_FFFF_FFFF},
            '{32'h5555_5555, 1'b0, 40'hFF_FFFF_FFFF},
            '{32'hAAAA_AAAA, 1'b0, 40'h00_0000_0001},
            '{32'h0000_0001, 1'b0, 40'h55_5555_5555},
            '{32'h8000_0000, 1'b1, 40'hAA_AAAA_AAAA},
            '{32'h0000_0100, 1'b0, 40'hAA_AAAA_AAAF},
            '{32'h0000_0100, 1'b0, 40'hAA_AAAA_AAB5},
            '{32'h0000_0100, 1'b0, 40'hAA_AAAA_AAB6},
            '{32'h0000_0100, 1'b1, 40'hAA_AAAA_AAB7},
            '{32'h0000_0100, 1'b0, 40'hAA_AAAA_AAB8},
            '{32'h0000_0200, 1'b0, 40'hAA_AAAA_AAB9},
            '{32'h0000_0100, 1'b0, 40'hAA_AAAA_AABA},
            '{32'h0001_0000, 1'b0, 40'hAA_AAAA_AABB},
            '{32'h0000_0100, 1'b0, 40'hAA_AAAA_AABC}};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // While the window fills, every word is all zero.
        foreach (dir_rows[i])
            send_bar(dir_rows[i].price, dir_rows[i].missing, dir_rows[i].stamp, 1'b1, '0);
        stamp = dir_rows[19].stamp;

        for (int phase = 0; phase < 5; phase++) begin
            drain();
            case (phase)
                1: begin
                    write_reg(wdqs_pkg::CFG_GAP_LIMIT, 10'd0);
                    write_reg(wdqs_pkg::CFG_Z_LIMIT, 10'd1);
                    write_reg(wdqs_pkg::CFG_MISS_WGT, 10'd255);
                    write_reg(wdqs_pkg::CFG_OUTL_WGT, 10'd255);
                    write_reg(wdqs_pkg::CFG_GAP_WGT, 10'd255);
                end
                2: begin
                    write_reg(wdqs_pkg::CFG_GAP_LIMIT, 10'd1023);
                    write_reg(wdqs_pkg::CFG_Z_LIMIT, 10'd15);
                    write_reg(wdqs_pkg::CFG_MISS_WGT, 10'd0);
                    write_reg(wdqs_pkg::CFG_OUTL_WGT, 10'd0);
                    write_reg(wdqs_pkg::CFG_GAP_WGT, 10'd0);
                end
                3: begin
                    write_reg(wdqs_pkg::CFG_GAP_LIMIT, 10'd3);
                    write_reg(wdqs_pkg::CFG_Z_LIMIT, 10'd0);
                    write_reg(wdqs_pkg::CFG_MISS_WGT, 10'd200);
                    write_reg(wdqs_pkg::CFG_OUTL_WGT, 10'd1);
                    write_reg(wdqs_pkg::CFG_GAP_WGT, 10'd7);
                end
                4: begin
                    write_reg(wdqs_pkg::CFG_GAP_LIMIT, 10'($urandom_range(1, 40)));
                    write_reg(wdqs_pkg::CFG_Z_LIMIT, 10'($urandom_range(2, 4)));
                    write_reg(wdqs_pkg::CFG_MISS_WGT, 10'($urandom_range(0, 255)));
                    write_reg(wdqs_pkg::CFG_OUTL_WGT, 10'($urandom_range(0, 255)));
                    write_reg(wdqs_pkg::CFG_GAP_WGT, 10'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            cfg_wr_en <= 1'b0;
            span = 0;
            style = 0;
            base = $urandom;
            for (int i = 0; i < 206; i++) begin
                if (span == 0) begin
                    r = $urandom_range(0, 9);
                    style = (r < 6) ? 0 : r - 6;
                    span = (style == 2) ? $urandom_range(60, 75) : $urandom_range(20, 60);
                    base = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 65535);
                end
                span--;
                missing = ($urandom_range(0, 9) == 0);
                case (style)
                    1: price = base;
                    2: begin
                        price = $urandom;
                        missing = 1'b1;
                    end
                    3: price = $urandom;
                    default: price = ($urandom_range(0, 19) == 0) ? $urandom
                                     : base + $urandom_range(0, 255);
                endcase
                r = $urandom_range(0, 19);
                if (r < 12) stamp = stamp + $urandom_range(1, 2);
                else if (r < 14) stamp = stamp + gap_limit;
                else if (r < 16) stamp = stamp + gap_limit + 1;
                else if (r < 17) stamp = stamp + $urandom_range(0, 1100);
                else if (r < 19) stamp = stamp - $urandom_range(0, 3);
                else stamp = {8'($urandom), 32'($urandom)};
                send_bar(price, missing, stamp, 1'b0, '0);
            end
        end
        drain();
        if (mismatches == 0 && pending_scores.size() == 0)
            $display("window_data_quality_score_unit regression: pass");
        else
            $display("window_data_quality_score_unit regression: fail");
        $finish;
    end

endmodule

// ----- window_data_quality_score_unit.f -----
+incdir+rtl
rtl/wdqs_pkg.sv
rtl/wdqs_ram.sv
rtl/window_data_quality_score_unit.sv
bench/testbench.sv
